// File: rtl/escp_pkg.sv
// Shared widths, reset values and codes for the encoder speed PI controller.
`default_nettype none

package escp_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned TARGET_W      = 16;
  localparam int unsigned RPM_W         = 16;
  localparam int unsigned GAIN_W        = 16;
  localparam int unsigned DUTY_W        = 8;
  localparam int unsigned CMD_W         = 2;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned IN_DATA_W     = 48;
  localparam int unsigned OUT_DATA_W    = 32;
  localparam int unsigned AVG_DEPTH_DEF = 10;

  // Q8.8 gains: 2.1 and 0.1.
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd538;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd26;
  localparam logic [DATA_W-1:0] RPM_SCALE_RST  = 32'd4000000;
  localparam logic [DUTY_W-1:0] DUTY_LIMIT_RST = 8'd100;

  typedef enum logic [CMD_W-1:0] {
    CMD_EDGE  = 2'd0,
    CMD_CTRL  = 2'd1,
    CMD_STALL = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN  = 2'd0,
    CFG_INTEG_GAIN = 2'd1,
    CFG_RPM_SCALE  = 2'd2,
    CFG_DUTY_LIMIT = 2'd3
  } cfg_idx_e;

endpackage

`default_nettype wire

// File: rtl/encoder_speed_pi_controller_top.sv
// Top level of the encoder speed PI controller with anti-windup.
//
// One result transfer follows every input transfer and reports the duty, the
// direction and the measured speed held after that item. tuser carries the
// command: encoder edge, control tick or stall-check tick. An encoder edge
// that does not complete a batch and a stall-check tick go straight to the
// result; a control tick passes through a short chain of registered multiply
// and saturate steps. An edge that completes a batch of AVG_DEPTH periods
// reads the ring RAM one entry a cycle, forms the average from a two-step
// multiply by the reciprocal of the depth, and then has the serial divider
// form the speed, one quotient bit a cycle. The ring starts out as all ones
// through one valid bit per entry, so no clearing pass follows reset. A new
// item is taken while a finished result waits on the output. The user must
// write configuration only while no item is in flight; the block itself does
// not enforce it.
`default_nettype none

module encoder_speed_pi_controller_top #(
  parameter int unsigned AVG_DEPTH = escp_pkg::AVG_DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration write port.
  input  wire logic                             cfg_we_i,
  input  wire logic [escp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [escp_pkg::DATA_W-1:0]      cfg_data_i,
  // Input stream.
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // tdata, from bit 0: capture_time[31:0], target_rpm[47:32].
  input  wire logic [escp_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // tuser: command[1:0].
  input  wire logic [escp_pkg::CMD_W-1:0]       s_axis_tuser_i,
  // Output stream.
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // tdata, from bit 0: duty[7:0], reverse[8], speed_rpm[24:9], zero fill.
  output logic [escp_pkg::OUT_DATA_W-1:0]       m_axis_tdata_o
);

  import escp_pkg::*;

  localparam int unsigned SLOT_W = $clog2(AVG_DEPTH);
  localparam int unsigned CNT_W  = $clog2(AVG_DEPTH + 1);
  localparam int unsigned SUM_W  = DATA_W + $clog2(AVG_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(AVG_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_AVG   = CNT_W'(AVG_DEPTH);

  // Multiplying by the rounded-up reciprocal of the depth and dropping
  // AVG_SHIFT bits gives the exact truncated average for every ring sum.
  localparam int unsigned AVG_SHIFT = SUM_W + SLOT_W;
  localparam int unsigned PROD_W    = 2 * SUM_W + 1;
  localparam int unsigned LO_W      = SUM_W / 2;
  localparam logic [63:0] AVG_RECIP_FULL =
    ((64'd1 << AVG_SHIFT) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);
  localparam logic [PROD_W-1:0] AVG_RECIP = PROD_W'(AVG_RECIP_FULL);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_SUM   = 10'b0000000010,
    ST_AVGL  = 10'b0000000100,
    ST_AVGH  = 10'b0000001000,
    ST_DIVR  = 10'b0000010000,
    ST_PROD  = 10'b0000100000,
    ST_INTEG = 10'b0001000000,
    ST_RAW   = 10'b0010000000,
    ST_DUTY  = 10'b0100000000,
    ST_DONE  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [GAIN_W-1:0] prop_gain_q;
  logic [GAIN_W-1:0] integ_gain_q;
  logic [DATA_W-1:0] rpm_scale_q;
  logic [DUTY_W-1:0] duty_limit_q;

  // Controller state.
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic [AVG_DEPTH-1:0] ring_vld_q, ring_vld_d;
  logic [DATA_W-1:0]    prev_q, prev_d;
  logic [DATA_W-1:0]    avg_q, avg_d;
  logic [DATA_W-1:0]    avg_chk_q, avg_chk_d;
  logic [RPM_W-1:0]     rpm_q, rpm_d;
  logic [DATA_W-1:0]    integ_q, integ_d;
  logic [DUTY_W-1:0]    duty_q, duty_d;
  logic                 rev_q, rev_d;

  // Sequencing and datapath registers.
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              rd_vld_q;
  logic              div_go_q, div_go_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [PROD_W-1:0] avg_acc_q, avg_acc_d;
  logic [17:0]       err_q, err_d;
  logic [34:0]       prod_q, prod_d;
  logic [DATA_W-1:0] newi_q, newi_d;
  logic [49:0]       raw_q, raw_d;
  logic              out_vld_q, out_vld_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  // Ring RAM and divider hookup.
  logic              ram_we;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;
  logic [DATA_W-1:0] ring_word;
  logic [PROD_W-1:0] avg_prod;
  logic [DATA_W-1:0] div_dividend;
  logic [DATA_W-1:0] div_divisor;
  logic [DATA_W-1:0] div_quo;
  logic              div_done;

  // Input decode and combinational helpers.
  logic              in_xfer;
  logic [DATA_W-1:0] in_capture;
  logic [TARGET_W-1:0] in_target;
  logic [16:0]       tgt_ext;
  logic [16:0]       tgt_mag;
  logic [17:0]       err_in;
  logic [35:0]       isum;
  logic [32:0]       pi_sum;
  logic              raw_pos;
  logic              raw_over;
  logic              raw_neg;
  logic              err_pos;
  logic              err_neg;

  assign in_xfer    = s_axis_tvalid_i && s_axis_tready_o;
  assign in_capture = s_axis_tdata_i[DATA_W-1:0];
  assign in_target  = s_axis_tdata_i[DATA_W+TARGET_W-1:DATA_W];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  // The magnitude of -32768 needs the 17th bit.
  assign tgt_ext = {in_target[TARGET_W-1], in_target};
  assign tgt_mag = in_target[TARGET_W-1] ? (17'd0 - tgt_ext) : tgt_ext;
  assign err_in  = {1'b0, tgt_mag} - {2'b00, rpm_q};

  assign isum   = {{4{integ_q[DATA_W-1]}}, integ_q} + {prod_q[34], prod_q};
  assign pi_sum = {{7{err_q[17]}}, err_q, 8'b0} + {newi_q[DATA_W-1], newi_q};

  // Duty is raw / 65536 rounded toward zero; a negative raw above -65536
  // still gives a duty of zero without counting as below range.
  assign raw_pos  = !raw_q[49];
  assign raw_over = raw_pos && (raw_q[48:16] > {25'b0, duty_limit_q});
  assign raw_neg  = raw_q[49] && !((&raw_q[48:16]) && (|raw_q[15:0]));
  assign err_pos  = !err_q[17] && (|err_q);
  assign err_neg  = err_q[17];

  assign ram_wdata = in_capture - prev_q;
  assign ram_raddr = cnt_q[SLOT_W-1:0];
  assign ring_word = rd_vld_q ? ram_rdata : '1;

  // The upper half of the sum times the reciprocal, added to the lower half's
  // product registered in the cycle before.
  assign avg_prod = avg_acc_q +
                    ((PROD_W'(sum_q[SUM_W-1:LO_W]) * AVG_RECIP) << LO_W);

  assign div_dividend = rpm_scale_q;
  assign div_divisor  = avg_q;

  escp_ram #(
    .WIDTH (DATA_W),
    .DEPTH (AVG_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  escp_div #(
    .DIVIDEND_W (DATA_W),
    .DIVISOR_W  (DATA_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go_q),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  always_comb begin
    state_d    = state_q;
    slot_d     = slot_q;
    ring_vld_d = ring_vld_q;
    prev_d     = prev_q;
    avg_d      = avg_q;
    avg_chk_d  = avg_chk_q;
    rpm_d      = rpm_q;
    integ_d    = integ_q;
    duty_d     = duty_q;
    rev_d      = rev_q;
    cnt_d      = cnt_q;
    div_go_d   = 1'b0;
    sum_d      = sum_q;
    avg_acc_d  = avg_acc_q;
    err_d      = err_q;
    prod_d     = prod_q;
    newi_d     = newi_q;
    raw_d      = raw_q;
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;

    if (m_axis_tvalid_o && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (s_axis_tuser_i)
            CMD_EDGE: begin
              ram_we             = 1'b1;
              ring_vld_d[slot_q] = 1'b1;
              prev_d             = in_capture;
              if (slot_q == SLOT_LAST) begin
                slot_d  = '0;
                sum_d   = '0;
                cnt_d   = '0;
                state_d = ST_SUM;
              end else begin
                slot_d  = slot_q + SLOT_W'(1);
                state_d = ST_DONE;
              end
            end
            CMD_CTRL: begin
              rev_d   = in_target[TARGET_W-1];
              err_d   = err_in;
              state_d = ST_PROD;
            end
            CMD_STALL: begin
              if (avg_q == avg_chk_q) begin
                rpm_d = '0;
              end
              avg_chk_d = avg_q;
              state_d   = ST_DONE;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_SUM: begin
        // Each read is accumulated in the cycle after it is issued.
        if (cnt_q != CNT_AVG) begin
          ram_re = 1'b1;
        end
        if (cnt_q != '0) begin
          sum_d = sum_q + SUM_W'(ring_word);
        end
        if (cnt_q == CNT_AVG) begin
          state_d = ST_AVGL;
        end
        cnt_d = cnt_q + CNT_W'(1);
      end
      ST_AVGL: begin
        avg_acc_d = PROD_W'(sum_q[LO_W-1:0]) * AVG_RECIP;
        state_d   = ST_AVGH;
      end
      ST_AVGH: begin
        avg_d    = avg_prod[AVG_SHIFT +: DATA_W];
        div_go_d = 1'b1;
        state_d  = ST_DIVR;
      end
      ST_DIVR: begin
        // A zero average reads as full speed.
        if (div_done) begin
          rpm_d   = ((avg_q == '0) || (|div_quo[DATA_W-1:RPM_W])) ? '1
                                                                   : div_quo[RPM_W-1:0];
          state_d = ST_DONE;
        end
      end
      ST_PROD: begin
        prod_d  = $signed({18'b0, integ_gain_q}) * $signed({{17{err_q[17]}}, err_q});
        state_d = ST_INTEG;
      end
      ST_INTEG: begin
        // Saturate the integral step to the signed 32-bit range.
        if (!isum[35] && (|isum[34:31])) begin
          newi_d = 32'h7fff_ffff;
        end else if (isum[35] && !(&isum[34:31])) begin
          newi_d = 32'h8000_0000;
        end else begin
          newi_d = isum[DATA_W-1:0];
        end
        state_d = ST_RAW;
      end
      ST_RAW: begin
        raw_d   = $signed({34'b0, prop_gain_q}) * $signed({{17{pi_sum[32]}}, pi_sum});
        state_d = ST_DUTY;
      end
      ST_DUTY: begin
        // Anti-windup: drop the integral step when it pushes further into
        // saturation.
        if (raw_over) begin
          duty_d  = duty_limit_q;
          integ_d = err_pos ? integ_q : newi_q;
        end else if (raw_neg) begin
          duty_d  = '0;
          integ_d = err_neg ? integ_q : newi_q;
        end else begin
          duty_d  = raw_pos ? raw_q[23:16] : '0;
          integ_d = newi_q;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d  = 1'b1;
          out_data_d = OUT_DATA_W'({rpm_q, rev_q, duty_q});
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= PROP_GAIN_RST;
      integ_gain_q <= INTEG_GAIN_RST;
      rpm_scale_q  <= RPM_SCALE_RST;
      duty_limit_q <= DUTY_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PROP_GAIN:  prop_gain_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_INTEG_GAIN: integ_gain_q <= cfg_data_i[GAIN_W-1:0];
        CFG_RPM_SCALE:  rpm_scale_q  <= cfg_data_i;
        CFG_DUTY_LIMIT: duty_limit_q <= cfg_data_i[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      slot_q     <= '0;
      ring_vld_q <= '0;
      prev_q     <= '0;
      avg_q      <= '0;
      avg_chk_q  <= '0;
      rpm_q      <= '0;
      integ_q    <= '0;
      duty_q     <= '0;
      rev_q      <= 1'b0;
      cnt_q      <= '0;
      rd_vld_q   <= 1'b0;
      div_go_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      slot_q     <= slot_d;
      ring_vld_q <= ring_vld_d;
      prev_q     <= prev_d;
      avg_q      <= avg_d;
      avg_chk_q  <= avg_chk_d;
      rpm_q      <= rpm_d;
      integ_q    <= integ_d;
      duty_q     <= duty_d;
      rev_q      <= rev_d;
      cnt_q      <= cnt_d;
      if (ram_re) begin
        rd_vld_q <= ring_vld_q[ram_raddr];
      end
      div_go_q   <= div_go_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q      <= sum_d;
    avg_acc_q  <= avg_acc_d;
    err_q      <= err_d;
    prod_q     <= prod_d;
    newi_q     <= newi_d;
    raw_q      <= raw_d;
    out_data_q <= out_data_d;
  end

  a_div_done_in_div_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIVR))
    else $error("divider finished outside the divide state");

  a_slot_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(slot_q) < CNT_AVG)
    else $error("ring slot beyond the ring depth");

  a_write_marks_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> ring_vld_q[$past(slot_q)])
    else $error("ring entry written but not marked valid");

  a_read_only_in_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (state_q == ST_SUM && !ram_we))
    else $error("ring read outside the summing pass");

endmodule

`default_nettype wire

// File: rtl/escp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module escp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/escp_div.sv
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none

module escp_div #(
  parameter int unsigned DIVIDEND_W = 36,
  parameter int unsigned DIVISOR_W  = escp_pkg::DATA_W
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output logic      [DIVIDEND_W-1:0] quotient_o,
  output logic                       done_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  den_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(DIVIDEND_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // When the trial falls short it is below the divisor, so it fits.
      rem_d = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= divisor_i;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

`default_nettype wire
